[rtl/core/xbc_pkg.sv]
package xbc_pkg;

    // Field and register widths
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 7;
    localparam int ROUNDS_W  = 6;
    localparam int CFG_IDX_W = 3;

    // Default block capacity in words
    localparam int MAX_WORDS_DEFAULT = 64;

    // Round constant of the cipher
    localparam logic [DATA_W-1:0] XBC_DELTA = 32'h9e37_79b9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEC_ROUNDS = 3'd6;

    // Register reset values
    localparam logic [COUNT_W-1:0]  WORD_COUNT_RESET = 7'd2;
    localparam logic [ROUNDS_W-1:0] DEC_ROUNDS_RESET = 6'd9;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP0,
        ST_PREP1,
        ST_PREP2,
        ST_RUN,
        ST_EMIT
    } state_t;

endpackage

[rtl/core/xbc_ram.sv]
module xbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a same-address read returns the old word
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/xxtea_block_cipher_top.sv]
// Loads n words (one per start transfer, one per cycle), then mixes in place:
// setup states PREP0..PREP2, then R rounds of one step per word in ST_RUN, one
// read-modify-write per cycle on the word RAM (R = 6 + 52/n encrypting, DEC_ROUNDS
// decrypting, 0 meaning 1). The n results then come out of the registered RAM read in
// ST_EMIT on consecutive cycles; last_word marks the last. The receiver cannot stall.
// rst_n resets control and configuration registers asynchronously; RAM is not cleared.
module xxtea_block_cipher_top #(
    parameter int MAX_WORDS = xbc_pkg::MAX_WORDS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [xbc_pkg::DATA_W-1:0]      data_word,
    output logic                            done,
    output logic [xbc_pkg::DATA_W-1:0]      result_word,
    output logic                            last_word,
    input  logic                            cfg_we,
    input  logic [xbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xbc_pkg::DATA_W-1:0]      cfg_data
);

    localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int DW    = xbc_pkg::DATA_W;
    localparam int CW    = xbc_pkg::COUNT_W;
    localparam int RW    = xbc_pkg::ROUNDS_W;
    localparam int N_CAP = (MAX_WORDS > 127) ? 127 : MAX_WORDS;
    localparam logic [CW-1:0] N_MAX = CW'(N_CAP);

    // Full rounds when encrypting: 6 + 52/n
    function automatic logic [RW-1:0] enc_rounds(input logic [CW-1:0] n);
        logic [RW-1:0] r;
        begin
            if      (n <= 7'd2)  r = 6'd32;
            else if (n == 7'd3)  r = 6'd23;
            else if (n == 7'd4)  r = 6'd19;
            else if (n == 7'd5)  r = 6'd16;
            else if (n == 7'd6)  r = 6'd14;
            else if (n == 7'd7)  r = 6'd13;
            else if (n == 7'd8)  r = 6'd12;
            else if (n <= 7'd10) r = 6'd11;
            else if (n <= 7'd13) r = 6'd10;
            else if (n <= 7'd17) r = 6'd9;
            else if (n <= 7'd26) r = 6'd8;
            else if (n <= 7'd52) r = 6'd7;
            else                 r = 6'd6;
            enc_rounds = r;
        end
    endfunction

    // Mixing function of one step
    function automatic logic [DW-1:0] mix_word(
        input logic [DW-1:0] y,
        input logic [DW-1:0] z,
        input logic [DW-1:0] sum,
        input logic [DW-1:0] key
    );
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        begin
            a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
            b = (sum ^ y) + (key ^ z);
            mix_word = a ^ b;
        end
    endfunction

    // Configuration registers
    logic [DW-1:0]  key_reg [4];
    logic [CW-1:0]  word_count_reg;
    logic           direction_reg;
    logic [RW-1:0]  dec_rounds_reg;

    // Control and datapath registers
    xbc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  load_count_reg, load_count_next;
    logic [AW-1:0]  p_reg, p_next;
    logic [AW-1:0]  emit_reg, emit_next;
    logic [RW-1:0]  rounds_left_reg, rounds_left_next;
    logic [DW-1:0]  sum_reg, sum_next;
    logic [DW-1:0]  chain_reg, chain_next;
    logic [DW-1:0]  cur_reg, cur_next;
    logic           fwd_reg, fwd_next;
    logic           done_reg, done_next;
    logic           last_reg, last_next;

    // RAM port signals
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [DW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [DW-1:0]  ram_rdata;

    // Derived values
    logic [CW-1:0]  n_words;
    logic [AW-1:0]  n_m1;
    logic [CW-1:0]  load_count_inc;
    logic           load_in_range;
    logic           accept;
    logic           block_full;
    logic [RW-1:0]  dec_rounds_eff;
    logic [DW-1:0]  fetched;
    logic [DW-1:0]  y_word;
    logic [DW-1:0]  z_word;
    logic [1:0]     key_idx;
    logic [DW-1:0]  mix_val;
    logic [DW-1:0]  new_word;
    logic           last_step;
    logic           last_round;
    logic [AW-1:0]  p_step;
    logic [AW-1:0]  fetch_addr;
    logic           emit_last;

    // Saturate the block length to 2..N_MAX (MAX_WORDS, but at most 127)
    always_comb
    begin
        if (word_count_reg < 7'd2)
        begin
            n_words = 7'd2;
        end
        else if (word_count_reg > N_MAX)
        begin
            n_words = N_MAX;
        end
        else
        begin
            n_words = word_count_reg;
        end
    end

    assign n_m1           = AW'(n_words - 7'd1);
    assign load_count_inc = load_count_reg + 7'd1;
    assign load_in_range  = (32'(load_count_reg) < MAX_WORDS);
    assign accept         = start && (state_reg == xbc_pkg::ST_IDLE);
    assign block_full     = (load_count_inc >= n_words);
    assign dec_rounds_eff = (dec_rounds_reg == '0) ? 6'd1 : dec_rounds_reg;

    // Step datapath: take the forwarded word when the read hit the last write
    assign fetched  = fwd_reg ? chain_reg : ram_rdata;
    assign y_word   = direction_reg ? chain_reg : fetched;
    assign z_word   = direction_reg ? fetched : chain_reg;
    assign key_idx  = 2'(p_reg) ^ sum_reg[3:2];
    assign mix_val  = mix_word(y_word, z_word, sum_reg, key_reg[key_idx]);
    assign new_word = direction_reg ? (cur_reg - mix_val) : (cur_reg + mix_val);

    // Step index walk: up for encrypt, down for decrypt
    always_comb
    begin
        if (direction_reg)
        begin
            last_step = (p_reg == '0);
            p_step    = last_step ? n_m1 : (p_reg - AW'(1));
            fetch_addr = (p_step == '0) ? n_m1 : (p_step - AW'(1));
        end
        else
        begin
            last_step = (p_reg == n_m1);
            p_step    = last_step ? '0 : (p_reg + AW'(1));
            fetch_addr = (p_step == n_m1) ? '0 : (p_step + AW'(1));
        end
    end

    assign last_round = last_step && (rounds_left_reg == 6'd1);
    assign emit_last  = (emit_reg == n_m1);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]     <= '0;
            key_reg[1]     <= '0;
            key_reg[2]     <= '0;
            key_reg[3]     <= '0;
            word_count_reg <= xbc_pkg::WORD_COUNT_RESET;
            direction_reg  <= 1'b0;
            dec_rounds_reg <= xbc_pkg::DEC_ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xbc_pkg::REG_KEY0:       key_reg[0]     <= cfg_data;
                xbc_pkg::REG_KEY1:       key_reg[1]     <= cfg_data;
                xbc_pkg::REG_KEY2:       key_reg[2]     <= cfg_data;
                xbc_pkg::REG_KEY3:       key_reg[3]     <= cfg_data;
                xbc_pkg::REG_WORD_COUNT: word_count_reg <= cfg_data[CW-1:0];
                xbc_pkg::REG_DIRECTION:  direction_reg  <= cfg_data[0];
                xbc_pkg::REG_DEC_ROUNDS: dec_rounds_reg <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xbc_pkg::ST_IDLE:
            begin
                if (accept && block_full)
                begin
                    state_next = xbc_pkg::ST_PREP0;
                end
            end
            xbc_pkg::ST_PREP0: state_next = xbc_pkg::ST_PREP1;
            xbc_pkg::ST_PREP1: state_next = xbc_pkg::ST_PREP2;
            xbc_pkg::ST_PREP2: state_next = xbc_pkg::ST_RUN;
            xbc_pkg::ST_RUN:
            begin
                if (last_round)
                begin
                    state_next = xbc_pkg::ST_EMIT;
                end
            end
            xbc_pkg::ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = xbc_pkg::ST_IDLE;
                end
            end
            default: state_next = xbc_pkg::ST_IDLE;
        endcase
    end

    // RAM port control per state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = p_reg;
        ram_wdata = new_word;
        ram_raddr = emit_reg;
        case (state_reg)
            xbc_pkg::ST_IDLE:
            begin
                ram_we    = accept && load_in_range;
                ram_waddr = AW'(load_count_reg);
                ram_wdata = data_word;
            end
            xbc_pkg::ST_PREP0: ram_raddr = direction_reg ? '0 : n_m1;
            xbc_pkg::ST_PREP1: ram_raddr = direction_reg ? n_m1 : '0;
            xbc_pkg::ST_PREP2: ram_raddr = direction_reg ? AW'(n_words - 7'd2) : AW'(1);
            xbc_pkg::ST_RUN:
            begin
                ram_we    = 1'b1;
                ram_raddr = fetch_addr;
            end
            xbc_pkg::ST_EMIT:  ram_raddr = emit_reg;
            default: ;
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        load_count_next  = load_count_reg;
        p_next           = p_reg;
        emit_next        = emit_reg;
        rounds_left_next = rounds_left_reg;
        sum_next         = sum_reg;
        chain_next       = chain_reg;
        cur_next         = cur_reg;
        fwd_next         = fwd_reg;
        done_next        = (state_reg == xbc_pkg::ST_EMIT);
        last_next        = (state_reg == xbc_pkg::ST_EMIT) && emit_last;
        case (state_reg)
            xbc_pkg::ST_IDLE:
            begin
                // Count loaded words; close the block once it is full
                if (accept)
                begin
                    load_count_next = block_full ? '0 : load_count_inc;
                end
            end
            xbc_pkg::ST_PREP0:
            begin
                sum_next         = direction_reg ?
                                   32'(32'(dec_rounds_eff) * xbc_pkg::XBC_DELTA) :
                                   xbc_pkg::XBC_DELTA;
                rounds_left_next = direction_reg ? dec_rounds_eff : enc_rounds(n_words);
                p_next           = direction_reg ? n_m1 : '0;
                fwd_next         = 1'b0;
                emit_next        = '0;
            end
            xbc_pkg::ST_PREP1: chain_next = ram_rdata;
            xbc_pkg::ST_PREP2: cur_next   = ram_rdata;
            xbc_pkg::ST_RUN:
            begin
                // Write back the step, carry the new word, advance the index
                chain_next = new_word;
                cur_next   = fetched;
                fwd_next   = (fetch_addr == p_reg);
                p_next     = p_step;
                if (last_step)
                begin
                    rounds_left_next = rounds_left_reg - 6'd1;
                    sum_next = direction_reg ? (sum_reg - xbc_pkg::XBC_DELTA) :
                                               (sum_reg + xbc_pkg::XBC_DELTA);
                end
            end
            xbc_pkg::ST_EMIT: emit_next = emit_reg + AW'(1);
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= xbc_pkg::ST_IDLE;
            load_count_reg  <= '0;
            p_reg           <= '0;
            emit_reg        <= '0;
            rounds_left_reg <= '0;
            sum_reg         <= '0;
            fwd_reg         <= 1'b0;
            done_reg        <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            p_reg           <= p_next;
            emit_reg        <= emit_next;
            rounds_left_reg <= rounds_left_next;
            sum_reg         <= sum_next;
            fwd_reg         <= fwd_next;
            done_reg        <= done_next;
            last_reg        <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        cur_reg   <= cur_next;
    end

    // Word store
    xbc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Results come straight from the registered RAM read
    assign busy        = (state_reg != xbc_pkg::ST_IDLE);
    assign done        = done_reg;
    assign result_word = ram_rdata;
    assign last_word   = last_reg;

endmodule
